// File: hw/rtl/mjfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjfd_pkg
// shared types and constants of the mjpeg frame deframer
// ----------------------------------------------------------------------------
package mjfd_pkg;

	localparam int BYTE_W   = 8;
	localparam int DISP_W   = 13;
	localparam int DIM_W    = 16;
	localparam int LEN_W    = 17;
	localparam int STATUS_W = 2;
	localparam int SCALE_W  = 2;
	localparam int CFG_IDX_W = 1;

	// register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 1'd1;

	localparam logic [DISP_W-1:0] DISPLAY_WIDTH_RST  = 13'd800;
	localparam logic [DISP_W-1:0] DISPLAY_HEIGHT_RST = 13'd480;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

	// marker bytes
	localparam logic [BYTE_W-1:0] MK_FF   = 8'hFF;
	localparam logic [BYTE_W-1:0] MK_SOI  = 8'hD8;
	localparam logic [BYTE_W-1:0] MK_EOI  = 8'hD9;
	localparam logic [BYTE_W-1:0] MK_SOF0 = 8'hC0;
	localparam logic [BYTE_W-1:0] MK_SOF2 = 8'hC2;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    frame_len;
		logic                size_found;
		logic [DIM_W-1:0]    image_width;
		logic [DIM_W-1:0]    image_height;
		logic [SCALE_W-1:0]  scale_code;
	} mjfd_result_t;

endpackage

// File: hw/rtl/mjpeg_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjpeg_frame_deframer
// finds FF D8 .. FF D9 frames in an mjpeg byte stream and reports length,
// header size, downscale code, or a buffer overflow
// ----------------------------------------------------------------------------
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, data_byte           | byte items in
//  out     | out_valid, out_stall, status, frame_len,| result items out
//          | size_found, image_width, image_height,  |
//          | scale_code                              |
//  cfg     | cfg_we, cfg_addr, cfg_wdata             | register writes
//
// one byte item per cycle sustained while no result item waits on a stalled
// result register; a byte is captured in the input register, processed in
// mjfd_parse and its result item is loaded into the result register, which
// drives the output; throughput is set by the state update in mjfd_parse
// reset clears all scan state, the buffer count and both register stages;
// display limits come up at 800 x 480
// in_stall rises only when a byte that ends a frame or fills the buffer
// waits for a stalled result register
// ----------------------------------------------------------------------------
module mjpeg_frame_deframer #(
	parameter int BUFFER_BYTES    = 65536,
	parameter int HEADER_WINDOW   = 512,
	parameter int MIN_FRAME_BYTES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// byte items
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [mjfd_pkg::BYTE_W-1:0]      data_byte,
	// result items
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mjfd_pkg::STATUS_W-1:0]    status,
	output logic [mjfd_pkg::LEN_W-1:0]       frame_len,
	output logic                             size_found,
	output logic [mjfd_pkg::DIM_W-1:0]       image_width,
	output logic [mjfd_pkg::DIM_W-1:0]       image_height,
	output logic [mjfd_pkg::SCALE_W-1:0]     scale_code,
	// config writes
	input  logic                             cfg_we,
	input  logic [mjfd_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [mjfd_pkg::DISP_W-1:0]      cfg_wdata
);

	// input register
	logic                         valid_s1;
	logic [mjfd_pkg::BYTE_W-1:0]  byte_s1;

	logic [mjfd_pkg::DISP_W-1:0]  disp_w, disp_h;
	logic                         res_valid;
	mjfd_pkg::mjfd_result_t       res;
	logic                         can_load;
	logic                         advance;
	logic                         in_acc;
	mjfd_pkg::mjfd_result_t       out_res;

	// a byte that gives no result never waits on the output side
	assign advance  = valid_s1 && (!res_valid || can_load);
	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= data_byte;
		end
	end

	mjfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.disp_w    (disp_w),
		.disp_h    (disp_h)
	);

	// scan state and result build
	mjfd_parse #(
		.BUFFER_BYTES    (BUFFER_BYTES),
		.HEADER_WINDOW   (HEADER_WINDOW),
		.MIN_FRAME_BYTES (MIN_FRAME_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.byte_s1   (byte_s1),
		.disp_w    (disp_w),
		.disp_h    (disp_h),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	mjfd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.load_res  (res),
		.out_stall (out_stall),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign status       = out_res.status;
	assign frame_len    = out_res.frame_len;
	assign size_found   = out_res.size_found;
	assign image_width  = out_res.image_width;
	assign image_height = out_res.image_height;
	assign scale_code   = out_res.scale_code;

endmodule

// File: hw/rtl/mjfd_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjfd_parse
// marker scan, header capture and buffer accounting, one byte per fire cycle
// ----------------------------------------------------------------------------
module mjfd_parse #(
	parameter int BUFFER_BYTES    = 65536,
	parameter int HEADER_WINDOW   = 512,
	parameter int MIN_FRAME_BYTES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic [mjfd_pkg::BYTE_W-1:0]       byte_s1,
	input  logic [mjfd_pkg::DISP_W-1:0]       disp_w,
	input  logic [mjfd_pkg::DISP_W-1:0]       disp_h,
	output logic                              res_valid,
	output mjfd_pkg::mjfd_result_t            res
);

	localparam int CW = $clog2(BUFFER_BYTES);
	localparam int LW = CW + 1;
	localparam int HWB = $clog2(HEADER_WINDOW + 1);
	localparam int PW = ((LW > HWB) ? LW : HWB) + 1;

	localparam logic [1:0] HDR_LOOK    = 2'd0;
	localparam logic [1:0] HDR_COLLECT = 2'd1;
	localparam logic [1:0] HDR_FOUND   = 2'd2;
	localparam logic [1:0] HDR_GIVEUP  = 2'd3;

	localparam logic [2:0] IDX_H_HI = 3'd3;
	localparam logic [2:0] IDX_H_LO = 3'd4;
	localparam logic [2:0] IDX_W_HI = 3'd5;
	localparam logic [2:0] IDX_W_LO = 3'd6;

	logic [CW-1:0]               fill_q, fill_n;
	logic                        in_frame_q, in_frame_n;
	logic                        last_ff_q, last_ff_n;
	logic [CW-1:0]               off_q, off_n;
	logic [1:0]                  hdr_q, hdr_n;
	logic [2:0]                  idx_q, idx_n;
	logic [mjfd_pkg::DIM_W-1:0]  w_q, w_n, h_q, h_n;

	logic                        is_end, is_ovf, is_sof;
	logic [LW-1:0]               len;
	logic [PW-1:0]               last_pos;

	function automatic logic [mjfd_pkg::SCALE_W-1:0] fit_code(
		input logic [mjfd_pkg::DIM_W-1:0]  w,
		input logic [mjfd_pkg::DIM_W-1:0]  h,
		input logic [mjfd_pkg::DISP_W-1:0] dw,
		input logic [mjfd_pkg::DISP_W-1:0] dh
	);
		logic [16:0] wx, hx;
		wx = {1'b0, w};
		hx = {1'b0, h};
		if (wx <= {4'b0, dw} && hx <= {4'b0, dh})
			return 2'd0;
		else if (wx <= {3'b0, dw, 1'b0} && hx <= {3'b0, dh, 1'b0})
			return 2'd1;
		else if (wx <= {2'b0, dw, 2'b0} && hx <= {2'b0, dh, 2'b0})
			return 2'd2;
		else
			return 2'd3;
	endfunction

	always_comb begin
		fill_n     = fill_q + CW'(1);
		in_frame_n = in_frame_q;
		last_ff_n  = (byte_s1 == mjfd_pkg::MK_FF);
		off_n      = off_q;
		hdr_n      = hdr_q;
		idx_n      = idx_q;
		w_n        = w_q;
		h_n        = h_q;
		is_end     = 1'b0;
		is_sof     = (byte_s1 == mjfd_pkg::MK_SOF0) || (byte_s1 == mjfd_pkg::MK_SOF2);
		len        = {1'b0, off_q} + LW'(1);
		// last header byte sits 7 past the marker code byte
		last_pos   = PW'(off_q) + PW'(7);

		if (!in_frame_q) begin
			if (last_ff_q && byte_s1 == mjfd_pkg::MK_SOI) begin
				in_frame_n = 1'b1;
				off_n      = CW'(2);
				hdr_n      = HDR_LOOK;
				idx_n      = 3'd0;
				w_n        = '0;
				h_n        = '0;
			end
		end else begin
			off_n = off_q + CW'(1);
			if (hdr_q == HDR_COLLECT) begin
				case (idx_q)
					IDX_H_HI: h_n = {byte_s1, 8'h00};
					IDX_H_LO: h_n = {h_q[15:8], byte_s1};
					IDX_W_HI: w_n = {byte_s1, 8'h00};
					IDX_W_LO: begin
						w_n   = {w_q[15:8], byte_s1};
						hdr_n = HDR_FOUND;
					end
					default: ;
				endcase
				idx_n = idx_q + 3'd1;
			end else if (hdr_q == HDR_LOOK && last_ff_q && is_sof) begin
				if (last_pos < PW'(HEADER_WINDOW)) begin
					hdr_n = HDR_COLLECT;
					idx_n = 3'd0;
				end else begin
					hdr_n = HDR_GIVEUP;
				end
			end
			if (last_ff_q && byte_s1 == mjfd_pkg::MK_EOI) begin
				is_end     = 1'b1;
				in_frame_n = 1'b0;
				fill_n     = '0;
				last_ff_n  = 1'b0;
			end
		end

		is_ovf = !is_end && (fill_q == CW'(BUFFER_BYTES - 1));
		if (is_ovf) begin
			fill_n     = '0;
			in_frame_n = 1'b0;
			last_ff_n  = 1'b0;
			off_n      = '0;
			hdr_n      = HDR_LOOK;
			idx_n      = 3'd0;
			w_n        = '0;
			h_n        = '0;
		end
	end

	always_comb begin
		res_valid = is_end || is_ovf;
		res       = '0;
		if (is_ovf) begin
			res.status = mjfd_pkg::ST_OVERFLOW;
		end else begin
			res.frame_len = mjfd_pkg::LEN_W'(len);
			if (len < LW'(MIN_FRAME_BYTES)) begin
				res.status = mjfd_pkg::ST_TOO_SHORT;
			end else if (len >= LW'(BUFFER_BYTES)) begin
				res.status = mjfd_pkg::ST_TOO_LONG;
			end else begin
				res.status = mjfd_pkg::ST_OK;
				if (hdr_n == HDR_FOUND) begin
					res.size_found   = 1'b1;
					res.image_width  = w_n;
					res.image_height = h_n;
					res.scale_code   = fit_code(w_n, h_n, disp_w, disp_h);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			in_frame_q <= 1'b0;
			last_ff_q  <= 1'b0;
			off_q      <= '0;
			hdr_q      <= HDR_LOOK;
			idx_q      <= 3'd0;
			w_q        <= '0;
			h_q        <= '0;
		end else if (fire) begin
			fill_q     <= fill_n;
			in_frame_q <= in_frame_n;
			last_ff_q  <= last_ff_n;
			off_q      <= off_n;
			hdr_q      <= hdr_n;
			idx_q      <= idx_n;
			w_q        <= w_n;
			h_q        <= h_n;
		end
	end

endmodule

// File: hw/rtl/mjfd_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjfd_outq
// result register holding one item until the consumer takes it
// ----------------------------------------------------------------------------
module mjfd_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  mjfd_pkg::mjfd_result_t load_res,
	input  logic                   out_stall,
	output logic                   can_load,
	output logic                   out_valid,
	output mjfd_pkg::mjfd_result_t out_res
);

	logic                   valid_q;
	mjfd_pkg::mjfd_result_t res_q;

	// free when empty or when the held item leaves this cycle
	assign can_load  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

endmodule

// File: hw/rtl/mjfd_top_dummy_never.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjfd_cfg
// display limit registers written through the config port
// ----------------------------------------------------------------------------
module mjfd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mjfd_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [mjfd_pkg::DISP_W-1:0]    cfg_wdata,
	output logic [mjfd_pkg::DISP_W-1:0]    disp_w,
	output logic [mjfd_pkg::DISP_W-1:0]    disp_h
);

	logic [mjfd_pkg::DISP_W-1:0] disp_w_q, disp_h_q;

	assign disp_w = disp_w_q;
	assign disp_h = disp_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_w_q <= mjfd_pkg::DISPLAY_WIDTH_RST;
			disp_h_q <= mjfd_pkg::DISPLAY_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				mjfd_pkg::REG_DISPLAY_WIDTH:  disp_w_q <= cfg_wdata;
				mjfd_pkg::REG_DISPLAY_HEIGHT: disp_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the mjpeg frame deframer: byte streams go in
// through the valid/stall port, an in-bench frame tracker predicts every
// result item and a checker compares each one field by field; directed
// framing, header-window and scale cases come first, then random frame
// traffic under four idle/stall mixes and several display sizes
// ----------------------------------------------------------------------------
module tb_top;
	import mjfd_pkg::*;

	localparam int BUF_BYTES  = 65536;
	localparam int HDR_WINDOW = 512;
	localparam int MIN_LEN    = 64;
	localparam int QUIET_MAX  = 5000;

	// header byte positions after the sof marker byte
	localparam logic [3:0] HB_HEIGHT_HI = 4'd3;
	localparam logic [3:0] HB_HEIGHT_LO = 4'd4;
	localparam logic [3:0] HB_WIDTH_HI  = 4'd5;
	localparam logic [3:0] HB_WIDTH_LO  = 4'd6;

	typedef enum logic [1:0] {HDR_SEEK, HDR_COLLECT, HDR_FOUND, HDR_GAVE_UP} hdr_phase_t;
	typedef logic [BYTE_W-1:0] octet_q_t[$];

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [LEN_W-1:0]    frame_len;
	logic                size_found;
	logic [DIM_W-1:0]    image_width;
	logic [DIM_W-1:0]    image_height;
	logic [SCALE_W-1:0]  scale_code;
	logic                cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [DISP_W-1:0]   cfg_wdata = '0;

	mjpeg_frame_deframer #(
		.BUFFER_BYTES   (BUF_BYTES),
		.HEADER_WINDOW  (HDR_WINDOW),
		.MIN_FRAME_BYTES(MIN_LEN)
	) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// frame tracker: mirrors the deframer state, fills the result queue
	// ------------------------------------------------------------------
	logic [DISP_W-1:0] lim_w     = DISPLAY_WIDTH_RST;
	logic [DISP_W-1:0] lim_h     = DISPLAY_HEIGHT_RST;
	logic [LEN_W-1:0]  fill_cnt  = '0;
	logic [LEN_W-1:0]  frame_pos = '0;
	bit                in_frm    = 1'b0;
	bit                prev_ff   = 1'b0;
	hdr_phase_t        hdr       = HDR_SEEK;
	logic [3:0]        hdr_idx   = '0;
	logic [DIM_W-1:0]  w_hold    = '0;
	logic [DIM_W-1:0]  h_hold    = '0;

	mjfd_result_t pending[$];

	int idle_pct      = 0;
	int stall_pct     = 0;
	int failures      = 0;
	int bytes_sent    = 0;
	int results_made  = 0;
	int settings_used = 1;
	int status_seen[4] = '{0, 0, 0, 0};

	// smallest power-of-two shrink that fits the display limits
	function automatic logic [SCALE_W-1:0] fit_scale(input logic [DIM_W-1:0] w, h);
		int unsigned lw;
		int unsigned lh;
		lw = lim_w;
		lh = lim_h;
		for (int s = 0; s < 3; s++)
			if (w <= (lw << s) && h <= (lh << s))
				return 2'(s);
		return 2'd3;
	endfunction

	function automatic void track_byte(input logic [BYTE_W-1:0] b);
		bit           saw_ff;
		int unsigned  pos;
		mjfd_result_t res;
		saw_ff  = prev_ff;
		prev_ff = (b == MK_FF);
		fill_cnt++;
		if (!in_frm) begin
			if (saw_ff && b == MK_SOI) begin
				in_frm    = 1'b1;
				frame_pos = LEN_W'(2);
				hdr       = HDR_SEEK;
				hdr_idx   = '0;
				w_hold    = '0;
				h_hold    = '0;
			end
		end else begin
			pos = frame_pos;
			frame_pos++;
			if (hdr == HDR_COLLECT) begin
				case (hdr_idx)
					HB_HEIGHT_HI: h_hold = {b, 8'h00};
					HB_HEIGHT_LO: h_hold[7:0] = b;
					HB_WIDTH_HI:  w_hold = {b, 8'h00};
					HB_WIDTH_LO: begin
						w_hold[7:0] = b;
						hdr = HDR_FOUND;
					end
					default: ;
				endcase
				hdr_idx++;
			end else if (hdr == HDR_SEEK && saw_ff && (b == MK_SOF0 || b == MK_SOF2)) begin
				// the last size byte must still sit inside the header window
				hdr     = (pos + 7 < HDR_WINDOW) ? HDR_COLLECT : HDR_GAVE_UP;
				hdr_idx = '0;
			end
			if (saw_ff && b == MK_EOI) begin
				in_frm   = 1'b0;
				fill_cnt = '0;
				prev_ff  = 1'b0;
				res      = '0;
				res.frame_len = LEN_W'(pos + 1);
				if (pos + 1 < MIN_LEN)
					res.status = ST_TOO_SHORT;
				else if (pos + 1 >= BUF_BYTES)
					res.status = ST_TOO_LONG;
				else begin
					res.status = ST_OK;
					if (hdr == HDR_FOUND) begin
						res.size_found   = 1'b1;
						res.image_width  = w_hold;
						res.image_height = h_hold;
						res.scale_code   = fit_scale(w_hold, h_hold);
					end
				end
				pending.push_back(res);
				results_made++;
				return;
			end
		end
		// end marker wins over a full buffer on the same byte
		if (fill_cnt >= BUF_BYTES) begin
			fill_cnt  = '0;
			in_frm    = 1'b0;
			prev_ff   = 1'b0;
			frame_pos = '0;
			hdr       = HDR_SEEK;
			hdr_idx   = '0;
			w_hold    = '0;
			h_hold    = '0;
			res       = '0;
			res.status = ST_OVERFLOW;
			pending.push_back(res);
			results_made++;
		end
	endfunction

	// ------------------------------------------------------------------
	// result checker and receiver stall
	// ------------------------------------------------------------------
	function automatic void compare_field(input string name, input int unsigned want, got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		mjfd_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$display("%0t ns: result item with none expected, expected nothing, got status %0d len %0d",
					$time, status, frame_len);
				failures++;
			end else begin
				want = pending.pop_front();
				compare_field("status", want.status, status);
				compare_field("frame_len", want.frame_len, frame_len);
				compare_field("size_found", want.size_found, size_found);
				compare_field("image_width", want.image_width, image_width);
				compare_field("image_height", want.image_height, image_height);
				compare_field("scale_code", want.scale_code, scale_code);
				status_seen[want.status]++;
			end
		end
		out_stall <= arst_n ? ($urandom_range(99) < stall_pct) : 1'b0;
	end

	// ends the run if neither channel moves an item for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_MAX) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no item moved for %0d cycles", QUIET_MAX);
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_byte(input logic [BYTE_W-1:0] b);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		track_byte(b);
		bytes_sent++;
	endtask

	task automatic send_bytes(input octet_q_t q);
		foreach (q[i])
			push_byte(q[i]);
	endtask

	// frame body byte: never ff and never an end marker
	function automatic logic [BYTE_W-1:0] filler_byte();
		logic [BYTE_W-1:0] v;
		v = BYTE_W'($urandom_range(0, 253));
		return (v == MK_EOI) ? 8'h00 : v;
	endfunction

	function automatic void pad_to(ref octet_q_t q, input int n);
		while (q.size() < n)
			q.push_back(filler_byte());
	endfunction

	function automatic void add_sof(ref octet_q_t q, input bit sof2,
			input logic [DIM_W-1:0] w, h);
		q.push_back(MK_FF);
		q.push_back(sof2 ? MK_SOF2 : MK_SOF0);
		q.push_back(8'h00);
		q.push_back(8'h11);
		q.push_back(8'h08);
		q.push_back(h[15:8]);
		q.push_back(h[7:0]);
		q.push_back(w[15:8]);
		q.push_back(w[7:0]);
	endfunction

	// len counts start through end marker; hdr_at is the ff of the sof, < 0 for none
	task automatic send_frame(input int len, input int hdr_at, input bit sof2,
			input logic [DIM_W-1:0] w, h, input bit with_eoi);
		octet_q_t q;
		q.push_back(MK_FF);
		q.push_back(MK_SOI);
		if (hdr_at >= 2) begin
			pad_to(q, hdr_at);
			add_sof(q, sof2, w, h);
		end
		pad_to(q, len - 2);
		while (q.size() > len - 2)
			void'(q.pop_back());
		if (with_eoi) begin
			q.push_back(MK_FF);
			q.push_back(MK_EOI);
		end
		send_bytes(q);
	endtask

	task automatic sized_frame(input logic [DIM_W-1:0] w, h);
		send_frame(72, $urandom_range(2, 20), 1'($urandom_range(1)), w, h, 1'b1);
	endtask

	// both limits in back-to-back writes; only called with the block idle
	task automatic set_display(input logic [DISP_W-1:0] w, h);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_DISPLAY_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_addr  <= REG_DISPLAY_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we    <= 1'b0;
		lim_w = w;
		lim_h = h;
		settings_used++;
	endtask

	// ff d8 ff d9 always leaves the block outside a frame, then drain
	task automatic finish_phase();
		push_byte(MK_FF);
		push_byte(MK_SOI);
		push_byte(MK_FF);
		push_byte(MK_EOI);
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [DISP_W-1:0] rand_limit();
		case ($urandom_range(9))
			0:       return 13'd1;
			1:       return 13'h1FFF;
			default: return DISP_W'($urandom_range(1, 8191));
		endcase
	endfunction

	// dimensions clustered around the scale thresholds, plus wide spread
	function automatic logic [DIM_W-1:0] pick_dim(input logic [DISP_W-1:0] lim);
		int unsigned l;
		l = lim;
		case ($urandom_range(2))
			0:       return DIM_W'((l << $urandom_range(0, 3)) + $urandom_range(0, 2) - 1);
			1:       return DIM_W'($urandom_range(0, 65535));
			default: return DIM_W'($urandom_range(0, l * 9));
		endcase
	endfunction

	task automatic noise_burst(input int n);
		logic [BYTE_W-1:0] b;
		repeat (n) begin
			if ($urandom_range(9) < 3) begin
				case ($urandom_range(4))
					0:       b = MK_FF;
					1:       b = MK_SOI;
					2:       b = MK_EOI;
					3:       b = MK_SOF0;
					default: b = MK_SOF2;
				endcase
			end else
				b = BYTE_W'($urandom_range(0, 255));
			push_byte(b);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_stream_framing();
		octet_q_t q;
		idle_pct  = 0;
		stall_pct = 0;
		// junk, a lone d8, then ff ff d8 opens the first frame
		push_byte(8'h00);
		push_byte(MK_SOI);
		push_byte(8'h5A);
		push_byte(MK_FF);
		send_frame(4, -1, 1'b0, '0, '0, 1'b1);
		send_frame(MIN_LEN - 1, -1, 1'b0, '0, '0, 1'b1);
		send_frame(MIN_LEN, -1, 1'b0, '0, '0, 1'b1);
		send_frame(80, 2, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
		send_frame(90, 30, 1'b1, 16'h0000, 16'h0000, 1'b1);
		// repeated start marker and a second header inside one frame
		q.push_back(MK_FF);
		q.push_back(MK_SOI);
		q.push_back(8'h10);
		q.push_back(MK_FF);
		q.push_back(MK_SOI);
		add_sof(q, 1'b0, 16'd640, 16'd360);
		q.push_back(MK_FF);
		q.push_back(MK_SOI);
		add_sof(q, 1'b1, 16'd4000, 16'd3000);
		pad_to(q, 100);
		q.push_back(MK_FF);
		q.push_back(MK_EOI);
		// end marker with no frame open
		q.push_back(MK_FF);
		q.push_back(MK_EOI);
		send_bytes(q);
		// a frame with no end marker, closed by the next one
		send_frame(70, 5, 1'b0, 16'd320, 16'd240, 1'b0);
		send_frame(70, -1, 1'b0, '0, '0, 1'b1);
		finish_phase();
	endtask

	task automatic test_header_window();
		idle_pct  = 0;
		stall_pct = 0;
		// last size byte on the final window offset, then one past it
		send_frame(530, HDR_WINDOW - 9, 1'b0, 16'd1024, 16'd768, 1'b1);
		send_frame(530, HDR_WINDOW - 8, 1'b1, 16'd1024, 16'd768, 1'b1);
		// header cut off by the end marker
		send_frame(70, 62, 1'b0, 16'd100, 16'd100, 1'b1);
		// size found but the frame is too short
		send_frame(40, 2, 1'b0, 16'd100, 16'd100, 1'b1);
		finish_phase();
	endtask

	task automatic test_scale_choice();
		idle_pct  = 0;
		stall_pct = 0;
		// reset limits 800 x 480, both sides of each threshold
		sized_frame(16'd800, 16'd480);
		sized_frame(16'd801, 16'd480);
		sized_frame(16'd800, 16'd481);
		sized_frame(16'd1600, 16'd960);
		sized_frame(16'd1601, 16'd960);
		sized_frame(16'd3200, 16'd1920);
		sized_frame(16'd3200, 16'd1921);
		sized_frame(16'd6401, 16'd100);
		finish_phase();
		set_display(13'd1, 13'd1);
		sized_frame(16'd1, 16'd1);
		sized_frame(16'd2, 16'd2);
		sized_frame(16'd4, 16'd1);
		sized_frame(16'd5, 16'd1);
		finish_phase();
		set_display(13'h1FFF, 13'h1FFF);
		sized_frame(16'd8191, 16'd8191);
		sized_frame(16'd16382, 16'd1);
		sized_frame(16'd32764, 16'd32764);
		sized_frame(16'd32765, 16'd0);
		sized_frame(16'hFFFF, 16'hFFFF);
		finish_phase();
		// zero limits: only a zero dimension fits
		set_display(13'd0, 13'd0);
		sized_frame(16'd0, 16'd0);
		sized_frame(16'd0, 16'd1);
		sized_frame(16'd1, 16'd0);
		finish_phase();
		set_display(13'h1555, 13'h0AAA);
		sized_frame(16'd5461, 16'd2730);
		sized_frame(16'd10923, 16'd2730);
		finish_phase();
	endtask

	task automatic test_random_traffic(input int idle, stall, n_bytes, n_results);
		int first_byte;
		int first_result;
		int len;
		int hdr_at;
		int pick;
		idle_pct  = idle;
		stall_pct = stall;
		set_display(rand_limit(), rand_limit());
		first_byte   = bytes_sent;
		first_result = results_made;
		while (bytes_sent - first_byte < n_bytes || results_made - first_result < n_results) begin
			if ($urandom_range(99) < 10)
				noise_burst($urandom_range(1, 12));
			else begin
				pick = $urandom_range(99);
				if (pick < 50)
					len = $urandom_range(4, 80);
				else if (pick < 75)
					len = $urandom_range(MIN_LEN - 4, MIN_LEN + 4);
				else if (pick < 95)
					len = $urandom_range(80, 200);
				else
					len = $urandom_range(500, 560);
				pick = $urandom_range(99);
				if (pick < 25)
					hdr_at = -1;
				else if (len >= 520 && pick < 60)
					hdr_at = $urandom_range(HDR_WINDOW - 14, HDR_WINDOW - 4);
				else
					hdr_at = $urandom_range(2, (len > 13) ? len - 11 : 2);
				// a few frames lose their end marker
				send_frame(len, hdr_at, 1'($urandom_range(1)), pick_dim(lim_w),
					pick_dim(lim_h), $urandom_range(99) >= 5);
			end
		end
		finish_phase();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stream_framing();
		test_header_window();
		test_scale_choice();
		test_random_traffic(0, 0, 375, 10);
		test_random_traffic(68, 0, 375, 10);
		test_random_traffic(0, 68, 375, 10);
		test_random_traffic(17, 17, 375, 10);

		repeat (8) @(posedge clk);
		$display("run covered %0d stream bytes over %0d display settings", bytes_sent,
			settings_used);
		$display("results checked: %0d accepted, %0d too short, %0d too long, %0d overflow",
			status_seen[ST_OK], status_seen[ST_TOO_SHORT], status_seen[ST_TOO_LONG],
			status_seen[ST_OVERFLOW]);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
